>>> sv/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Types, constants and helpers shared by the fixed-point ALU pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 32;
  localparam int NUM_W     = DATA_W + FRAC_BITS;   // dividend width, one cell per bit
  localparam int PROD_W    = 2 * DATA_W;
  localparam int MAG_W     = PROD_W + 1;          // widest magnitude that gets saturated

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MAX = 3'd4,
    OP_MIN = 3'd5,
    OP_INC = 3'd6,
    OP_DEC = 3'd7
  } fpa_op_t;

  // item as it travels through the divider chain
  typedef struct packed {
    fpa_op_t                  op;
    logic                     less;
    logic                     equal;
    logic                     greater;
    logic signed [DATA_W-1:0] simple_val;   // result of add, sub, max, min, inc, dec
    logic                     simple_ovf;
    logic                     dbz;
    logic                     neg;          // sign of product and quotient
    logic [DATA_W-1:0]        mag_a;
    logic [DATA_W-1:0]        mag_b;
    logic [NUM_W-1:0]         num;          // dividend bits still to shift in
    logic [DATA_W-1:0]        rem;
    logic [NUM_W-1:0]         quot;
  } fpa_item_t;

  // item after the product and quotient rounding stage
  typedef struct packed {
    fpa_op_t                  op;
    logic                     less;
    logic                     equal;
    logic                     greater;
    logic signed [DATA_W-1:0] simple_val;
    logic                     simple_ovf;
    logic                     dbz;
    logic                     neg;
    logic [PROD_W-1:0]        prod;
    logic [NUM_W:0]           qdiv;
  } fpa_post_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     less;
    logic                     equal;
    logic                     greater;
    logic                     ovf;
    logic                     dbz;
  } fpa_res_t;

  // saturate a sign and magnitude to the signed data range, ovf in the top bit
  function automatic logic [DATA_W:0] sat_mag(input logic [MAG_W-1:0] mag, input logic neg);
    logic [MAG_W-1:0]  lim;
    logic [DATA_W-1:0] v;
    logic              o;
    lim = {{(MAG_W-DATA_W){1'b0}}, 1'b1, {(DATA_W-1){1'b0}}};
    if (neg) begin
      o = mag > lim;
      v = o ? {1'b1, {(DATA_W-1){1'b0}}} : (~mag[DATA_W-1:0] + 1'b1);
    end else begin
      o = mag > (lim - 1'b1);
      v = o ? {1'b0, {(DATA_W-1){1'b1}}} : mag[DATA_W-1:0];
    end
    return {o, v};
  endfunction

  // saturate a signed sum one bit wider than the data range
  function automatic logic [DATA_W:0] sat_sum(input logic [DATA_W:0] s);
    logic o;
    o = s[DATA_W] != s[DATA_W-1];
    if (o) return {1'b1, s[DATA_W], {(DATA_W-1){~s[DATA_W]}}};
    return {1'b0, s[DATA_W-1:0]};
  endfunction

endpackage

`default_nettype wire

>>> sv/fpa_prep.sv
// ----------------------------------------------------------------------------
// fpa_prep
// Entry stage: compares, simple ops, magnitudes and divider setup.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_prep (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [2:0]                            opcode,
  input  logic signed [fpa_pkg::DATA_W-1:0]     operand_a,
  input  logic signed [fpa_pkg::DATA_W-1:0]     operand_b,
  output logic                                  out_valid,
  output fpa_pkg::fpa_item_t                    out_item
);
  import fpa_pkg::*;

  fpa_item_t         it;
  logic [DATA_W:0]   ax, bx;
  logic [DATA_W-1:0] one;

  // build the item
  always_comb begin
    ax  = {operand_a[DATA_W-1], operand_a};
    bx  = {operand_b[DATA_W-1], operand_b};
    one = {{(DATA_W-1){1'b0}}, 1'b1};
    it = '0;
    it.op      = fpa_op_t'(opcode);
    it.less    = operand_a < operand_b;
    it.equal   = operand_a == operand_b;
    it.greater = operand_a > operand_b;
    it.mag_a   = operand_a[DATA_W-1] ? (~operand_a + one) : operand_a;
    it.mag_b   = operand_b[DATA_W-1] ? (~operand_b + one) : operand_b;
    it.neg     = operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
    it.num     = {it.mag_a, {FRAC_BITS{1'b0}}};
    it.dbz     = (it.op == OP_DIV) && (operand_b == '0);
    unique case (it.op)
      OP_ADD:  {it.simple_ovf, it.simple_val} = sat_sum(ax + bx);
      OP_SUB:  {it.simple_ovf, it.simple_val} = sat_sum(ax - bx);
      OP_INC:  {it.simple_ovf, it.simple_val} = sat_sum(ax + {1'b0, one});
      OP_DEC:  {it.simple_ovf, it.simple_val} = sat_sum(ax - {1'b0, one});
      OP_MAX:  {it.simple_ovf, it.simple_val} = {1'b0, it.greater ? operand_a : operand_b};
      OP_MIN:  {it.simple_ovf, it.simple_val} = {1'b0, it.less ? operand_a : operand_b};
      default: {it.simple_ovf, it.simple_val} = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= it;
    end
  end

endmodule

`default_nettype wire

>>> sv/fpa_cell.sv
// ----------------------------------------------------------------------------
// fpa_cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  fpa_pkg::fpa_item_t in_item,
  output logic               out_valid,
  output fpa_pkg::fpa_item_t out_item
);
  import fpa_pkg::*;

  fpa_item_t       it;
  logic [DATA_W:0] trial;
  logic [DATA_W:0] diff;
  logic            qbit;

  // shift in next dividend bit, subtract divisor if it fits
  always_comb begin
    it    = in_item;
    trial = {in_item.rem, in_item.num[NUM_W-1]};
    diff  = trial - {1'b0, in_item.mag_b};
    qbit  = trial >= {1'b0, in_item.mag_b};
    it.rem  = qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
    it.num  = {in_item.num[NUM_W-2:0], 1'b0};
    it.quot = {in_item.quot[NUM_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= it;
    end
  end

endmodule

`default_nettype wire

>>> sv/fpa_post.sv
// ----------------------------------------------------------------------------
// fpa_post
// Two tail stages: product and quotient rounding, then saturation and select.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_post (
  input  logic               clk,
  input  logic               rst,
  input  logic               en1,
  input  logic               en2,
  input  logic               in_valid,
  input  fpa_pkg::fpa_item_t in_item,
  output logic               mid_valid,
  output logic               out_valid,
  output fpa_pkg::fpa_res_t  out_res
);
  import fpa_pkg::*;

  fpa_post_t         p1, mid;
  fpa_res_t          res;
  logic              rnd_up;
  logic [MAG_W-1:0]  mul_mag;
  logic [DATA_W:0]   mul_sat, div_sat;
  logic [MAG_W-1:0]  half;

  // stage one: magnitude product, quotient round half up
  always_comb begin
    rnd_up        = {in_item.rem, 1'b0} >= {1'b0, in_item.mag_b};
    p1.op         = in_item.op;
    p1.less       = in_item.less;
    p1.equal      = in_item.equal;
    p1.greater    = in_item.greater;
    p1.simple_val = in_item.simple_val;
    p1.simple_ovf = in_item.simple_ovf;
    p1.dbz        = in_item.dbz;
    p1.neg        = in_item.neg;
    p1.prod       = in_item.mag_a * in_item.mag_b;
    p1.qdiv       = {1'b0, in_item.quot} + {{NUM_W{1'b0}}, rnd_up};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (en1) begin
      mid_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      mid <= p1;
    end
  end

  // stage two: scale, saturate, pick by opcode
  always_comb begin
    half    = {{(MAG_W-1){1'b0}}, 1'b1} << FRAC_BITS >> 1;
    mul_mag = ({1'b0, mid.prod} + half) >> FRAC_BITS;
    mul_sat = sat_mag(mul_mag, mid.neg);
    div_sat = sat_mag({{(MAG_W-NUM_W-1){1'b0}}, mid.qdiv}, mid.neg);
    res.less    = mid.less;
    res.equal   = mid.equal;
    res.greater = mid.greater;
    res.dbz     = mid.dbz;
    unique case (mid.op)
      OP_MUL:  {res.ovf, res.value} = mul_sat;
      OP_DIV:  {res.ovf, res.value} = mid.dbz ? '0 : div_sat;
      default: {res.ovf, res.value} = {mid.simple_ovf, mid.simple_val};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en2) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

>>> sv/fixed_point_alu_q8.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_q8
// Signed Q24.8 ALU: add, sub, mul, div, max, min, inc, dec with saturation.
// ----------------------------------------------------------------------------
// One item per cycle enters and one result per cycle leaves while out_ready is
// high. The pipeline is an entry stage, a chain of one restoring-division cell
// per quotient bit, a product/rounding stage and a saturation stage. Every op
// passes the whole chain, so results leave in order.
// Each stage moves on when it is empty or its successor moves, so bubbles
// close up and new items are taken while a result waits at the output.
`default_nettype none

module fixed_point_alu_q8 (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        opcode,
  input  logic signed [fpa_pkg::DATA_W-1:0] operand_a,
  input  logic signed [fpa_pkg::DATA_W-1:0] operand_b,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [fpa_pkg::DATA_W-1:0] value,
  output logic                              a_less,
  output logic                              a_equal,
  output logic                              a_greater,
  output logic                              overflow,
  output logic                              divide_by_zero
);
  import fpa_pkg::*;

  // stage 0 is the entry stage, stages 1..NUM_W are cells
  logic      v   [0:NUM_W];
  fpa_item_t itm [0:NUM_W];
  logic      rdy [0:NUM_W];
  logic      mid_valid, rdy_mid, rdy_out;
  fpa_res_t  res;

  // stall chain
  assign rdy_out = !out_valid || out_ready;
  assign rdy_mid = !mid_valid || rdy_out;
  assign rdy[NUM_W] = !v[NUM_W] || rdy_mid;
  for (genvar k = 0; k < NUM_W; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end
  assign in_ready = rdy[0];

  fpa_prep u_prep (
    .clk(clk), .rst(rst), .en(rdy[0]), .in_valid(in_valid),
    .opcode(opcode), .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(v[0]), .out_item(itm[0])
  );

  // division cells
  for (genvar k = 1; k <= NUM_W; k++) begin : g_cell
    fpa_cell u_cell (
      .clk(clk), .rst(rst), .en(rdy[k]), .in_valid(v[k-1]), .in_item(itm[k-1]),
      .out_valid(v[k]), .out_item(itm[k])
    );
  end

  fpa_post u_post (
    .clk(clk), .rst(rst), .en1(rdy_mid), .en2(rdy_out),
    .in_valid(v[NUM_W]), .in_item(itm[NUM_W]),
    .mid_valid(mid_valid), .out_valid(out_valid), .out_res(res)
  );

  assign value          = res.value;
  assign a_less         = res.less;
  assign a_equal        = res.equal;
  assign a_greater      = res.greater;
  assign overflow       = res.ovf;
  assign divide_by_zero = res.dbz;

  // checks
  a_cmp_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({a_less, a_equal, a_greater}))
    else $error("compare flags not one-hot");

  a_dbz_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_by_zero) |-> (value == '0 && !overflow))
    else $error("divide by zero result not clean");

  a_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(value)))
    else $error("stalled result changed");

endmodule

`default_nettype wire
